[design/rbs_pkg.sv]
// Shared constants, codes and types for the ring buffer with statistics.
package rbs_pkg;

  localparam int DEPTH_DEF      = 5;
  localparam int NUM_AGENTS_DEF = 256;
  localparam int ITEM_WIDTH_DEF = 8;

  localparam int AGENT_W = 8;
  localparam int DATA_W  = 8;
  localparam int OCC_W   = 3;
  localparam int ACNT_W  = 24;
  localparam int TOT_W   = 32;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 168;

  typedef logic [1:0]        status_t;
  typedef logic [ACNT_W-1:0] acnt_t;
  typedef logic [TOT_W-1:0]  tot_t;

  localparam logic    REQ_INSERT = 1'b0;
  localparam logic    REQ_REMOVE = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  function automatic acnt_t sat_inc24(input acnt_t v);
    sat_inc24 = (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic tot_t sat_inc32(input tot_t v);
    sat_inc32 = (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

[design/rbs_ram.sv]
// Simple dual-port synchronous RAM, registered read with enable.
module rbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ring_buffer_with_statistics_core.sv]
// Top level: circular FIFO with per-agent and global occupancy counters.
//
//  channel  | dir | tdata                            | tuser
//  s_axis   | in  | agent_id[7:0] item_in[15:8]      | req_type
//  m_axis   | out | item_out, occupancy, agent_count, | status
//           |     | totals, full/empty times         |
//
// Per request: the accept edge launches the RAM reads (slot and count tables)
// and enters the update state, which does the read-modify-write and loads the
// result register once the output is free.
// After reset a clearing pass zeroes both count tables with s_tready low. A
// held result stalls the update cycle only; one new request may be accepted
// while a result waits.
module ring_buffer_with_statistics_core
  import rbs_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int NUM_AGENTS = NUM_AGENTS_DEF,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // agent_id[7:0], item_in[15:8]
  input  logic                   s_tuser,  // req_type
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // item_out[7:0], occupancy[10:8], agent_count[34:11], total_produced[66:35],
  // total_consumed[98:67], full_times[130:99], empty_times[162:131], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output status_t                m_tuser   // status
);

  localparam int IW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int AW = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
  localparam int XW = (AW > AGENT_W) ? AW : AGENT_W;
  localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(NUM_AGENTS - 1);
  localparam logic [10:0]   NA       = 11'(NUM_AGENTS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic                  state;
  logic                  clearing;
  logic [AW-1:0]         clr_cnt;
  logic [IW-1:0]         wr_idx;
  logic [IW-1:0]         rd_idx;
  logic [FW-1:0]         fill;
  tot_t                  prod_tot;
  tot_t                  cons_tot;
  tot_t                  full_cnt;
  tot_t                  empty_cnt;

  logic                  req_rem;
  logic                  req_ok_agent;
  logic [AW-1:0]         req_addr;
  logic [ITEM_WIDTH-1:0] req_item;

  logic                  accept;
  logic                  upd;
  logic [AGENT_W-1:0]    in_agent;
  logic [DATA_W-1:0]     in_item;
  logic [XW-1:0]         agent_x;

  acnt_t                 prod_q;
  acnt_t                 cons_q;
  logic [ITEM_WIDTH-1:0] slot_q;

  logic                  op_ok;
  status_t               status;
  acnt_t                 cnt_rd;
  acnt_t                 cnt_new;
  acnt_t                 agent_count;
  logic [DATA_W-1:0]     item_out;
  logic [FW-1:0]         fill_next;
  tot_t                  res_prod;
  tot_t                  res_cons;
  tot_t                  res_full;
  tot_t                  res_empty;

  logic                  prod_we;
  logic                  cons_we;
  logic [AW-1:0]         cnt_waddr;
  acnt_t                 cnt_wdata;
  logic                  slot_we;

  assign in_agent = s_tdata[AGENT_W-1:0];
  assign in_item  = s_tdata[AGENT_W +: DATA_W];
  assign agent_x  = XW'(in_agent);

  assign s_tready = !clearing && (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign upd      = (state == S_UPD) && (!m_tvalid || m_tready);

  always_comb begin
    cnt_rd  = req_rem ? cons_q : prod_q;
    cnt_new = sat_inc24(cnt_rd);
    if (req_rem == REQ_INSERT) begin
      op_ok  = (fill != FILL_MAX);
      status = op_ok ? ST_OK : ST_FULL;
    end else begin
      op_ok  = (fill != '0);
      status = op_ok ? ST_OK : ST_EMPTY;
    end
    if (!req_ok_agent) begin
      agent_count = '0;
    end else if (op_ok) begin
      agent_count = cnt_new;
    end else begin
      agent_count = cnt_rd;
    end
    item_out  = (op_ok && req_rem == REQ_REMOVE) ? DATA_W'(slot_q) : '0;
    fill_next = fill;
    if (op_ok) begin
      fill_next = (req_rem == REQ_INSERT) ? fill + 1'b1 : fill - 1'b1;
    end
  end

  assign res_prod  = (op_ok && req_rem == REQ_INSERT) ? sat_inc32(prod_tot) : prod_tot;
  assign res_cons  = (op_ok && req_rem == REQ_REMOVE) ? sat_inc32(cons_tot) : cons_tot;
  assign res_full  = (op_ok && req_rem == REQ_INSERT && fill_next == FILL_MAX)
                     ? sat_inc32(full_cnt) : full_cnt;
  assign res_empty = (op_ok && req_rem == REQ_REMOVE && fill_next == '0)
                     ? sat_inc32(empty_cnt) : empty_cnt;

  always_comb begin
    prod_we   = upd && op_ok && req_ok_agent && (req_rem == REQ_INSERT);
    cons_we   = upd && op_ok && req_ok_agent && (req_rem == REQ_REMOVE);
    cnt_waddr = req_addr;
    cnt_wdata = cnt_new;
    if (clearing) begin
      prod_we   = 1'b1;
      cons_we   = 1'b1;
      cnt_waddr = clr_cnt;
      cnt_wdata = '0;
    end
    slot_we = upd && op_ok && (req_rem == REQ_INSERT);
  end

  rbs_ram #(.WIDTH(ACNT_W), .DEPTH(NUM_AGENTS)) u_prod_ram (
    .clk   (clk),
    .we    (prod_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (accept),
    .raddr (agent_x[AW-1:0]),
    .rdata (prod_q)
  );

  rbs_ram #(.WIDTH(ACNT_W), .DEPTH(NUM_AGENTS)) u_cons_ram (
    .clk   (clk),
    .we    (cons_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (accept),
    .raddr (agent_x[AW-1:0]),
    .rdata (cons_q)
  );

  rbs_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (wr_idx),
    .wdata (req_item),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (slot_q)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req_rem      <= s_tuser;
      req_ok_agent <= ({3'b000, in_agent} < NA);
      req_addr     <= agent_x[AW-1:0];
      req_item     <= ITEM_WIDTH'(in_item);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      wr_idx    <= '0;
      rd_idx    <= '0;
      fill      <= '0;
      prod_tot  <= '0;
      cons_tot  <= '0;
      full_cnt  <= '0;
      empty_cnt <= tot_t'(1);
      m_tvalid  <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == CLR_LAST) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        state <= S_UPD;
      end else if (upd) begin
        state <= S_IDLE;
      end
      if (upd) begin
        m_tvalid <= 1'b1;
        fill     <= fill_next;
        if (op_ok && req_rem == REQ_INSERT) begin
          wr_idx   <= (wr_idx == IDX_LAST) ? '0 : wr_idx + 1'b1;
          prod_tot <= sat_inc32(prod_tot);
          if (fill_next == FILL_MAX) begin
            full_cnt <= sat_inc32(full_cnt);
          end
        end
        if (op_ok && req_rem == REQ_REMOVE) begin
          rd_idx   <= (rd_idx == IDX_LAST) ? '0 : rd_idx + 1'b1;
          cons_tot <= sat_inc32(cons_tot);
          if (fill_next == '0) begin
            empty_cnt <= sat_inc32(empty_cnt);
          end
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      m_tuser <= status;
      m_tdata <= OUT_TDATA_W'({res_empty, res_full, res_cons, res_prod, agent_count,
                               OCC_W'(fill_next), item_out});
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= FILL_MAX)
    else $error("fill level beyond depth");

  a_no_req_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (state == S_IDLE) && !m_tvalid)
    else $error("request in flight during table clear");

  a_load_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_UPD))
    else $error("result loaded outside update cycle");

  a_upd_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_UPD))
    else $error("accepted request did not reach update");

endmodule

[dv/ring_buffer_with_statistics_core_tb.sv]
// Self-checking testbench for the ring buffer with statistics: directed and random requests.
module ring_buffer_with_statistics_core_tb;
  import rbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int PW = $clog2(DEPTH_DEF);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH_DEF - 1);

  typedef struct {
    logic             kind;
    logic [AGENT_W-1:0] agent;
    logic [DATA_W-1:0]  item;
    int               gap;
    bit               drain;
  } fifo_req_t;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  item_out;
    logic [OCC_W-1:0]   occupancy;
    acnt_t              agent_count;
    tot_t               total_produced;
    tot_t               total_consumed;
    tot_t               full_times;
    tot_t               empty_times;
  } fifo_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = REQ_INSERT;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  status_t                m_tuser;

  fifo_req_t    req_q[$];
  fifo_result_t result_q[$];
  fifo_req_t    cur;
  int           gap_left = 0;
  int           stall_left = 0;
  int           rx_mode = 0;
  int           rx_cycles = 0;
  int           mismatches = 0;

  // predictor state
  logic [DATA_W-1:0] ring [DEPTH_DEF];
  logic [PW-1:0]     wr_ptr = '0;
  logic [PW-1:0]     rd_ptr = '0;
  int                level = 0;
  acnt_t             prod_cnt [NUM_AGENTS_DEF];
  acnt_t             cons_cnt [NUM_AGENTS_DEF];
  tot_t              produced = '0;
  tot_t              consumed = '0;
  tot_t              full_events = '0;
  tot_t              empty_events = 32'd1;

  ring_buffer_with_statistics_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic acnt_t bump24(acnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic tot_t bump32(tot_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic fifo_result_t fifo_stats_update(fifo_req_t r);
    fifo_result_t res;
    res = '0;
    res.status = ST_OK;
    if (r.kind == REQ_INSERT) begin
      if (level == DEPTH_DEF) begin
        res.status = ST_FULL;
      end else begin
        ring[wr_ptr] = r.item;
        wr_ptr = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
        level++;
        produced = bump32(produced);
        prod_cnt[r.agent] = bump24(prod_cnt[r.agent]);
        if (level == DEPTH_DEF) full_events = bump32(full_events);
      end
      res.agent_count = prod_cnt[r.agent];
    end else begin
      if (level == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.item_out = ring[rd_ptr];
        rd_ptr = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
        level--;
        consumed = bump32(consumed);
        cons_cnt[r.agent] = bump24(cons_cnt[r.agent]);
        if (level == 0) empty_events = bump32(empty_events);
      end
      res.agent_count = cons_cnt[r.agent];
    end
    res.occupancy      = level[OCC_W-1:0];
    res.total_produced = produced;
    res.total_consumed = consumed;
    res.full_times     = full_events;
    res.empty_times    = empty_events;
    return res;
  endfunction

  function automatic int idle_len();
    return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  task automatic add_req(logic kind, logic [7:0] agent, logic [7:0] item, int gap, bit drain);
    fifo_req_t r;
    r.kind  = kind;
    r.agent = agent;
    r.item  = item;
    r.gap   = gap;
    r.drain = drain;
    req_q.push_back(r);
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) result_q.push_back(fifo_stats_update(cur));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (req_q.size() != 0 && !(req_q[0].drain && result_q.size() != 0)) begin
          cur = req_q.pop_front();
          gap_left = cur.gap;
          s_tvalid <= 1'b1;
          s_tdata  <= {cur.item, cur.agent};
          s_tuser  <= cur.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    fifo_result_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $error("result with no request outstanding: status %0d", m_tuser);
          mismatches++;
        end else begin
          e = result_q.pop_front();
          check_field("status", e.status, m_tuser);
          check_field("item_out", e.item_out, m_tdata[7:0]);
          check_field("occupancy", e.occupancy, m_tdata[10:8]);
          check_field("agent_count", e.agent_count, m_tdata[34:11]);
          check_field("total_produced", e.total_produced, m_tdata[66:35]);
          check_field("total_consumed", e.total_consumed, m_tdata[98:67]);
          check_field("full_times", e.full_times, m_tdata[130:99]);
          check_field("empty_times", e.empty_times, m_tdata[162:131]);
        end
      end
      rx_cycles++;
      if (rx_cycles % 256 == 0) rx_mode = $urandom_range(0, 2);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_mode != 0 && $urandom_range(0, 99) < (rx_mode == 1 ? 10 : 40)) begin
        stall_left = idle_len() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("ring_buffer_with_statistics_core_tb NOT OK");
    $finish;
  end

  initial begin
    int  mode;
    int  seg_len;
    int  ins_pct;
    bit  quiet;
    int  gap;
    logic kind;
    logic [7:0] agent;

    foreach (prod_cnt[i]) prod_cnt[i] = '0;
    foreach (cons_cnt[i]) cons_cnt[i] = '0;

    // directed: empty refusal, fill to full, full refusal, drain, wrapped pointers
    add_req(REQ_REMOVE, 8'h00, 8'h00, 0, 0);
    add_req(REQ_INSERT, 8'h00, 8'h00, 0, 0);
    add_req(REQ_INSERT, 8'hFF, 8'hFF, 0, 0);
    add_req(REQ_INSERT, 8'hAA, 8'h55, 1, 0);
    add_req(REQ_INSERT, 8'h55, 8'hAA, 0, 0);
    add_req(REQ_INSERT, 8'h01, 8'h80, 0, 0);
    add_req(REQ_INSERT, 8'h02, 8'h7F, 0, 0);
    add_req(REQ_REMOVE, 8'hFF, 8'hFF, 0, 0);
    add_req(REQ_REMOVE, 8'h00, 8'h00, 2, 0);
    add_req(REQ_REMOVE, 8'hFF, 8'h00, 0, 0);
    add_req(REQ_REMOVE, 8'h80, 8'h00, 0, 0);
    add_req(REQ_REMOVE, 8'h7F, 8'h00, 0, 0);
    add_req(REQ_REMOVE, 8'h7F, 8'h00, 0, 0);
    for (int i = 0; i < 3; i++) add_req(REQ_INSERT, 8'h03, 8'(8'h10 + i), 0, 0);
    for (int i = 0; i < 2; i++) add_req(REQ_REMOVE, 8'h04, 8'h00, 0, 0);
    for (int i = 0; i < 4; i++) add_req(REQ_INSERT, 8'h03, 8'(8'hF0 + i), 0, 0);
    add_req(REQ_INSERT, 8'hFF, 8'h01, 0, 0);
    for (int i = 0; i < 6; i++) add_req(REQ_REMOVE, 8'h04, 8'h00, 0, 0);

    // random: segments biased toward filling, draining or balanced traffic
    for (int n = 0; n < 1500; ) begin
      mode    = $urandom_range(0, 2);
      ins_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      seg_len = $urandom_range(5, 30);
      quiet   = ($urandom_range(0, 99) < 30);
      for (int k = 0; k < seg_len; k++) begin
        kind = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
        case ($urandom_range(0, 9))
          0, 1, 2: agent = 8'($urandom_range(0, 255));
          3: agent = 8'hFF;
          default: agent = 8'($urandom_range(0, 7));
        endcase
        if (quiet || $urandom_range(0, 99) < 70) gap = 0;
        else gap = idle_len();
        add_req(kind, agent, 8'($urandom_range(0, 255)), gap, (n % 300 == 0));
        n++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (req_q.size() != 0 || s_tvalid || result_q.size() != 0);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && result_q.size() == 0) begin
      $display("ring_buffer_with_statistics_core_tb OK");
    end else begin
      $display("ring_buffer_with_statistics_core_tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
design/rbs_pkg.sv
design/rbs_ram.sv
design/ring_buffer_with_statistics_core.sv
dv/ring_buffer_with_statistics_core_tb.sv
